>>> sv/mpt_pkg.sv
// ----------------------------------------------------------------------------
// Multichannel period tachometer package
// Shared types, field widths, register indexes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package mpt_pkg;

  localparam int SPEED_W     = 24;
  localparam int STOP_W      = 8;
  localparam int CH_FIELD_W  = 3;
  localparam int CAP_W       = 16;
  localparam int MAX_RESULTS = 6;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_RPM_SCALE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_TICKS = 1'b1;

  localparam logic [SPEED_W-1:0] RPM_SCALE_RST  = 24'd300000;
  localparam logic [STOP_W-1:0]  STOP_TICKS_RST = 8'd20;
  localparam logic [STOP_W-1:0]  IDLE_MAX       = 8'hFF;

  localparam logic REQ_CAPTURE = 1'b0;
  localparam logic REQ_TICK    = 1'b1;

  typedef struct packed {
    logic                  req_type;
    logic [CH_FIELD_W-1:0] channel;
    logic [CAP_W-1:0]      capture_value;
  } in_item_t;

  typedef struct packed {
    logic [CH_FIELD_W-1:0] out_channel;
    logic [SPEED_W-1:0]    speed_rpm;
    logic                  stopped;
    logic                  last;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_CAP_PUT,
    ST_TICK
  } mpt_state_t;

endpackage : mpt_pkg

`default_nettype wire

>>> sv/mpt_divider.sv
// ----------------------------------------------------------------------------
// Serial restoring divider
// Computes one quotient bit per cycle; the quotient holds until next start.
// ----------------------------------------------------------------------------
`default_nettype none

module mpt_divider
  import mpt_pkg::*;
#(
  parameter int DIVISOR_W = 17
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  start,
  input  wire  [SPEED_W-1:0]   dividend,
  input  wire  [DIVISOR_W-1:0] divisor,
  output logic                 done,
  output logic [SPEED_W-1:0]   quotient
);

  localparam int CNT_W = $clog2(SPEED_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(SPEED_W - 1);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [DIVISOR_W-1:0] rem_r, rem_nxt;
  logic [DIVISOR_W-1:0] dsr_r, dsr_nxt;
  logic [SPEED_W-1:0]   quo_r, quo_nxt;

  logic [DIVISOR_W:0] partial;
  logic [DIVISOR_W:0] diff;
  logic               ge;

  assign partial = {rem_r, quo_r[SPEED_W-1]};
  assign ge      = partial >= {1'b0, dsr_r};
  assign diff    = partial - {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      // The dividend shifts out of the top as quotient bits shift in below.
      rem_nxt = ge ? diff[DIVISOR_W-1:0] : partial[DIVISOR_W-1:0];
      quo_nxt = {quo_r[SPEED_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST_STEP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

`ifndef NO_ASSERTIONS
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider started while busy");
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (rem_r < dsr_r))
    else $error("final remainder not below divisor");
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("done without a running division");
`endif

endmodule : mpt_divider

`default_nettype wire

>>> sv/multichannel_period_tachometer.sv
// Capture transaction: accepted in ST_IDLE, divided in ST_DIVIDE by the serial divider
//   at one quotient bit per cycle, then written to the output from ST_CAP_PUT.
// Tick transaction: one channel per cycle over all CHANNELS, held while a reported channel waits for the output.
// One transaction is worked on at a time; the output register lets the next
//   transaction be accepted while the last result waits.
// Synchronous active-low reset clears all channel state and loads register defaults.
// ----------------------------------------------------------------------------
// Multichannel period tachometer
// Per-channel period capture, serial speed division and idle-tick stop logic.
// ----------------------------------------------------------------------------
`default_nettype none

module multichannel_period_tachometer
  import mpt_pkg::*;
#(
  parameter int CHANNELS   = 6,
  parameter int TIMER_BITS = 16
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wire  in_item_t        in_data,
  output logic                  out_valid,
  input  wire                   out_ready,
  output out_item_t             out_data,
  input  wire                   cfg_we,
  input  wire  [CFG_IDX_W-1:0]  cfg_index,
  input  wire  [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int N_OUT = (CHANNELS < MAX_RESULTS) ? CHANNELS : MAX_RESULTS;
  localparam logic [4:0] CH_COUNT = 5'(CHANNELS);
  localparam logic [CH_W-1:0] CH_LAST  = CH_W'(CHANNELS - 1);
  localparam logic [4:0]      OUT_LAST = 5'(N_OUT - 1);

  // Configuration registers
  logic [SPEED_W-1:0] rpm_scale_r;
  logic [STOP_W-1:0]  stop_ticks_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rpm_scale_r  <= RPM_SCALE_RST;
      stop_ticks_r <= STOP_TICKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RPM_SCALE:  rpm_scale_r  <= cfg_wdata[SPEED_W-1:0];
        CFG_STOP_TICKS: stop_ticks_r <= cfg_wdata[STOP_W-1:0];
        default: ;
      endcase
    end
  end

  // Channel state
  logic [TIMER_BITS-1:0] last_cap_r [CHANNELS];
  logic [TIMER_BITS-1:0] last_cap_nxt [CHANNELS];
  logic [SPEED_W-1:0]    speed_r [CHANNELS];
  logic [SPEED_W-1:0]    speed_nxt [CHANNELS];
  logic [STOP_W-1:0]     idle_r [CHANNELS];
  logic [STOP_W-1:0]     idle_nxt [CHANNELS];

  mpt_state_t state_r, state_nxt;
  logic [CH_W-1:0]       ch_r, ch_nxt;
  logic [TIMER_BITS-1:0] cap_r, cap_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_data_r, out_data_nxt;

  // Input decode
  logic [TIMER_BITS+CAP_W-1:0] cap_wide;
  logic [TIMER_BITS-1:0]       cap_in;
  logic [4:0]                  in_ch_ext;
  logic [CH_W-1:0]             in_ch;
  logic                        in_ch_ok;
  logic                        accept;

  assign cap_wide  = {{TIMER_BITS{1'b0}}, in_data.capture_value};
  assign cap_in    = cap_wide[TIMER_BITS-1:0];
  assign in_ch_ext = {2'b00, in_data.channel};
  assign in_ch     = in_ch_ext[CH_W-1:0];
  assign in_ch_ok  = in_ch_ext < CH_COUNT;
  assign accept    = in_valid && in_ready;

  // Period: a zero difference means a full timer wrap, which the extra MSB carries.
  logic [TIMER_BITS-1:0] diff;
  logic [TIMER_BITS:0]   period;

  assign diff   = cap_in - last_cap_r[in_ch];
  assign period = {(diff == '0), diff};

  logic               div_start;
  logic               div_done;
  logic [SPEED_W-1:0] div_quo;

  mpt_divider #(
    .DIVISOR_W (TIMER_BITS + 1)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (rpm_scale_r),
    .divisor  (period),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Tick step values for the channel under the sequencer
  logic [4:0]        ch_ext;
  logic [STOP_W-1:0] idle_inc;
  logic              tick_stop;
  logic              tick_report;
  logic              slot_free;

  assign ch_ext      = 5'(ch_r);
  assign idle_inc    = (idle_r[ch_r] == IDLE_MAX) ? IDLE_MAX : idle_r[ch_r] + 1'b1;
  assign tick_stop   = idle_inc >= stop_ticks_r;
  assign tick_report = ch_ext < 5'(N_OUT);
  assign slot_free   = !out_valid_r || out_ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_data.req_type == REQ_TICK) begin
            state_nxt = ST_TICK;
          end else if (in_ch_ok) begin
            state_nxt = ST_DIVIDE;
          end
        end
      end
      ST_DIVIDE: begin
        if (div_done) begin
          state_nxt = ST_CAP_PUT;
        end
      end
      ST_CAP_PUT: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_TICK: begin
        if ((!tick_report || slot_free) && ch_r == CH_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs and datapath
  always_comb begin
    in_ready      = 1'b0;
    div_start     = 1'b0;
    ch_nxt        = ch_r;
    cap_nxt       = cap_r;
    last_cap_nxt  = last_cap_r;
    speed_nxt     = speed_r;
    idle_nxt      = idle_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (accept) begin
          if (in_data.req_type == REQ_TICK) begin
            ch_nxt = '0;
          end else if (in_ch_ok) begin
            ch_nxt    = in_ch;
            cap_nxt   = cap_in;
            div_start = 1'b1;
          end
        end
      end
      ST_DIVIDE: ;
      ST_CAP_PUT: begin
        if (slot_free) begin
          speed_nxt[ch_r]          = div_quo;
          last_cap_nxt[ch_r]       = cap_r;
          idle_nxt[ch_r]           = '0;
          out_valid_nxt            = 1'b1;
          out_data_nxt.out_channel = ch_ext[CH_FIELD_W-1:0];
          out_data_nxt.speed_rpm   = div_quo;
          out_data_nxt.stopped     = 1'b0;
          out_data_nxt.last        = 1'b1;
        end
      end
      ST_TICK: begin
        if (!tick_report || slot_free) begin
          idle_nxt[ch_r] = tick_stop ? '0 : idle_inc;
          if (tick_stop) begin
            speed_nxt[ch_r] = '0;
          end
          if (tick_report) begin
            out_valid_nxt            = 1'b1;
            out_data_nxt.out_channel = ch_ext[CH_FIELD_W-1:0];
            out_data_nxt.speed_rpm   = tick_stop ? '0 : speed_r[ch_r];
            out_data_nxt.stopped     = tick_stop;
            out_data_nxt.last        = (ch_ext == OUT_LAST);
          end
          if (ch_r != CH_LAST) begin
            ch_nxt = ch_r + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      ch_r        <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        last_cap_r[i] <= '0;
        speed_r[i]    <= '0;
        idle_r[i]     <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      ch_r        <= ch_nxt;
      last_cap_r  <= last_cap_nxt;
      speed_r     <= speed_nxt;
      idle_r      <= idle_nxt;
    end
    cap_r      <= cap_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  a_capture_divides: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.req_type == REQ_CAPTURE && in_ch_ok) |=> state_r == ST_DIVIDE)
    else $error("valid capture did not start a division");
  a_done_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIVIDE)
    else $error("divider finished outside the divide state");
  a_tick_index: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_TICK |-> ch_ext < CH_COUNT)
    else $error("tick channel index out of range");
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.req_type == REQ_TICK) |=> !in_ready)
    else $error("input accepted during a tick sweep");
`endif

endmodule : multichannel_period_tachometer

`default_nettype wire

>>> dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Multichannel period tachometer testbench
// Sends capture and tick transactions with random gaps and output stalls,
// predicts every speed report and checks each one field by field.
// ----------------------------------------------------------------------------

module testbench
  import mpt_pkg::*;
;

  localparam int N_CH          = 6;
  localparam int TIMER_W       = 16;
  localparam int SETTLE_CYCLES = 40;
  localparam int STALL_LIMIT   = 5000;
  localparam int PHASE_ITEMS   = 80;

  class speed_scoreboard;
    logic [SPEED_W-1:0] rpm_scale;
    logic [STOP_W-1:0]  stop_ticks;
    logic [CAP_W-1:0]   last_cap [N_CH];
    logic [SPEED_W-1:0] speed [N_CH];
    logic [STOP_W-1:0]  idle_count [N_CH];
    out_item_t          expected_reports [$];
    int                 errors, reports_checked, captures, ticks, stops, ignored;

    function new();
      rpm_scale  = RPM_SCALE_RST;
      stop_ticks = STOP_TICKS_RST;
      foreach (last_cap[i]) begin
        last_cap[i]   = '0;
        speed[i]      = '0;
        idle_count[i] = '0;
      end
      errors          = 0;
      reports_checked = 0;
      captures        = 0;
      ticks           = 0;
      stops           = 0;
      ignored         = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      if (index == CFG_RPM_SCALE) begin
        rpm_scale = data[SPEED_W-1:0];
      end else begin
        stop_ticks = data[STOP_W-1:0];
      end
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction

    // Updates the channel state for one accepted transaction and queues the
    // speed reports that it should produce.
    function void predict_speeds(in_item_t item);
      logic [CAP_W-1:0] diff;
      logic [CAP_W:0]   period;
      out_item_t        rep;
      int               n_rep;
      if (item.req_type == REQ_CAPTURE) begin
        if (item.channel >= N_CH) begin
          ignored++;
          return;
        end
        captures++;
        diff   = item.capture_value - last_cap[item.channel];
        // A zero difference means a full timer revolution between edges.
        period = (diff == '0) ? {1'b1, {CAP_W{1'b0}}} : {1'b0, diff};
        speed[item.channel]      = rpm_scale / SPEED_W'(period);
        last_cap[item.channel]   = item.capture_value;
        idle_count[item.channel] = '0;
        rep.out_channel = item.channel;
        rep.speed_rpm   = speed[item.channel];
        rep.stopped     = 1'b0;
        rep.last        = 1'b1;
        expected_reports.push_back(rep);
        return;
      end
      ticks++;
      n_rep = (N_CH < MAX_RESULTS) ? N_CH : MAX_RESULTS;
      for (int i = 0; i < N_CH; i++) begin
        rep.stopped = 1'b0;
        if (idle_count[i] != IDLE_MAX) idle_count[i]++;
        if (idle_count[i] >= stop_ticks) begin
          speed[i]      = '0;
          idle_count[i] = '0;
          rep.stopped   = 1'b1;
          stops++;
        end
        if (i < n_rep) begin
          rep.out_channel = CH_FIELD_W'(i);
          rep.speed_rpm   = speed[i];
          rep.last        = (i == n_rep - 1);
          expected_reports.push_back(rep);
        end
      end
    endfunction

    function void compare_field(string name, logic [SPEED_W-1:0] want,
                                logic [SPEED_W-1:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void check_speed_report(out_item_t got);
      out_item_t want;
      if (expected_reports.size() == 0) begin
        errors++;
        $display("%0t: unexpected report, expected none, got ch %0d speed %0d %s %0b %0b",
                 $time, got.out_channel, got.speed_rpm, "stopped/last", got.stopped,
                 got.last);
        return;
      end
      want = expected_reports.pop_front();
      reports_checked++;
      compare_field("out_channel", SPEED_W'(want.out_channel), SPEED_W'(got.out_channel));
      compare_field("speed_rpm", want.speed_rpm, got.speed_rpm);
      compare_field("stopped", SPEED_W'(want.stopped), SPEED_W'(got.stopped));
      compare_field("last", SPEED_W'(want.last), SPEED_W'(got.last));
    endfunction
  endclass

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_RPM_SCALE;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  logic                  calm         = 1'b0;
  int                    quiet_cycles = 0;
  logic [CAP_W-1:0]      sent_cap [N_CH];
  speed_scoreboard       scoreboard;

  always #1 clk = ~clk;

  multichannel_period_tachometer #(
    .CHANNELS   (N_CH),
    .TIMER_BITS (TIMER_W)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Both handshakes are sampled here, so prediction and checking see the
  // values that the block saw at the same edge.
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 6);
    if (rst_n) begin
      if (in_valid && in_ready) scoreboard.predict_speeds(in_data);
      if (out_valid && out_ready) scoreboard.check_speed_report(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
    $display("multichannel_period_tachometer verification failed");
    $finish;
  end

  task automatic send_item(input in_item_t item);
    while (!calm && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_capture(input logic [CH_FIELD_W-1:0] ch, input logic [CAP_W-1:0] value);
    in_item_t item;
    item.req_type      = REQ_CAPTURE;
    item.channel       = ch;
    item.capture_value = value;
    if (ch < N_CH) sent_cap[ch] = value;
    send_item(item);
  endtask

  task automatic send_tick();
    in_item_t item;
    // Channel and timer fields are don't-care on a tick; fill them randomly.
    item.req_type      = REQ_TICK;
    item.channel       = CH_FIELD_W'($urandom);
    item.capture_value = CAP_W'($urandom);
    send_item(item);
  endtask

  // Holds the sender off until every report is in, then lets the block finish
  // any capture that reports nothing.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (scoreboard.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(input logic [SPEED_W-1:0] rpm, input logic [STOP_W-1:0] stop);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_RPM_SCALE;
    cfg_wdata <= rpm;
    @(posedge clk);
    scoreboard.write_reg(CFG_RPM_SCALE, rpm);
    cfg_index <= CFG_STOP_TICKS;
    cfg_wdata <= CFG_DATA_W'(stop);
    @(posedge clk);
    scoreboard.write_reg(CFG_STOP_TICKS, CFG_DATA_W'(stop));
    cfg_we <= 1'b0;
  endtask

  // Mostly plausible pulse trains per channel, with some full-range noise and
  // captures on channels that do not exist.
  task automatic random_traffic(input int n);
    int               counted;
    int               pick;
    int               ch;
    logic [CAP_W-1:0] value;
    counted = 0;
    while (counted < n) begin
      pick = $urandom_range(99);
      if (pick < 22) begin
        send_tick();
        counted++;
      end else if (pick < 26) begin
        send_capture(CH_FIELD_W'($urandom_range(7, N_CH)), CAP_W'($urandom));
      end else begin
        ch   = $urandom_range(N_CH - 1);
        pick = $urandom_range(99);
        if (pick < 50) begin
          value = sent_cap[ch] + CAP_W'($urandom_range(2000, 1));
        end else if (pick < 65) begin
          value = sent_cap[ch] + CAP_W'($urandom_range(4, 1));
        end else if (pick < 75) begin
          value = sent_cap[ch];
        end else begin
          value = CAP_W'($urandom);
        end
        send_capture(CH_FIELD_W'(ch), value);
        counted++;
      end
    end
  endtask

  initial begin
    scoreboard = new();
    foreach (sent_cap[i]) sent_cap[i] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Reset register values. The first capture on a channel measures from zero.
    send_capture(3'd0, 16'h0000);
    send_capture(3'd0, 16'h0001);
    send_capture(3'd0, 16'h0000);
    send_capture(3'd5, 16'hFFFF);
    send_capture(3'd5, 16'hFFFF);
    send_capture(3'd6, 16'h1234);
    send_capture(3'd7, 16'hFFFF);
    send_capture(3'd1, 16'h5555);
    send_capture(3'd2, 16'hAAAA);
    send_capture(3'd3, 16'h00FF);
    send_capture(3'd4, 16'hFF00);
    send_tick();
    settle();

    // Full-scale speed on a one-count period, and a single tick stops everything.
    write_regs('1, 8'd1);
    send_capture(3'd1, 16'h5556);
    send_capture(3'd2, 16'hAAAB);
    send_tick();
    send_tick();
    settle();

    // Zero scale gives zero speed, and zero stop count stops on every tick.
    write_regs('0, 8'd0);
    send_capture(3'd3, 16'h0100);
    send_capture(3'd4, 16'hFF01);
    send_tick();
    settle();

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: write_regs(RPM_SCALE_RST, STOP_TICKS_RST);
        1: write_regs('1, 8'd255);
        2: write_regs(24'd1, 8'd1);
        3: write_regs(SPEED_W'($urandom_range(24'hFFFFFF, 1)), STOP_W'($urandom_range(6, 2)));
        default: write_regs(SPEED_W'($urandom), STOP_W'($urandom));
      endcase
      calm <= (phase == 3);
      random_traffic(PHASE_ITEMS);
      settle();
    end

    $display("Run covered %0d captures, %0d ticks and %0d captures on absent channels.",
             scoreboard.captures, scoreboard.ticks, scoreboard.ignored);
    $display("Checked %0d speed reports over seven register settings; %0d channel stops.",
             scoreboard.reports_checked, scoreboard.stops);
    if (scoreboard.errors == 0) begin
      $display("multichannel_period_tachometer verification clean");
    end else begin
      $display("multichannel_period_tachometer verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
sv/mpt_pkg.sv
sv/mpt_divider.sv
sv/multichannel_period_tachometer.sv
dv/testbench.sv
